FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the histogram checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CHIST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CHIST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/chist_pkg.sv
// ----------------------------------------------------------------------------
// Channel histogram package
// Types, codes and constants shared by the histogram block.
// ----------------------------------------------------------------------------
package chist_pkg;

  localparam int NUM_BINS       = 256;
  localparam int BIN_BITS       = 8;
  localparam int LEVEL_BITS     = 8;
  localparam int COUNT_BITS_DEF = 20;
  localparam int TOTAL_BITS     = 20;
  localparam int BAR_BITS       = 10;
  localparam int OP_BITS        = 2;
  localparam int CHAN_BITS      = 2;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 10;

  localparam logic [BAR_BITS-1:0] DEFAULT_CANVAS = BAR_BITS'(125);

  localparam logic [OP_BITS-1:0] OP_COUNT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAN_BITS-1:0] CHAN_BLUE  = 2'd0;
  localparam logic [CHAN_BITS-1:0] CHAN_GREEN = 2'd1;
  localparam logic [CHAN_BITS-1:0] CHAN_RED   = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_SELECT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_HEIGHT  = 2'd1;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [LEVEL_BITS-1:0] blue_level;
    logic [LEVEL_BITS-1:0] green_level;
    logic [LEVEL_BITS-1:0] red_level;
    logic [BIN_BITS-1:0]   bin_index;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] bin_total;
    logic [TOTAL_BITS-1:0] peak_total;
    logic [BAR_BITS-1:0]   bar_height;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  reg_index;
    logic [CFG_DATA_BITS-1:0] wr_data;
  } cfg_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic cnt_upd;
    logic mul;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scale;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/chist_stream_if.sv
// ----------------------------------------------------------------------------
// Histogram stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface chist_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/chist_ctrl.sv
// ----------------------------------------------------------------------------
// Histogram controller
// Sequences count, read and clear transactions over the datapath.
// ----------------------------------------------------------------------------
module chist_ctrl
  import chist_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [OP_BITS-1:0] in_op,
  output logic               in_ready,
  input  status_t            status,
  output cmd_t               cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          priority if (in_op == OP_COUNT) begin
            state_nxt = ST_CNT;
          end else if (in_op == OP_READ) begin
            state_nxt = ST_MUL;
          end else if (in_op == OP_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CNT: begin
        cmd.cnt_upd = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!status.scale) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
          if (status.div_last) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/chist_dp.sv
// ----------------------------------------------------------------------------
// Histogram datapath
// Bin memory, peak tracking, bar scaling divider and result register.
// ----------------------------------------------------------------------------
module chist_dp
  import chist_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  cfg_item_t cfg_data,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int PROD_W = COUNT_BITS + BAR_BITS;
  localparam int DIVC_W = $clog2(BAR_BITS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   vld_r;
  logic [COUNT_BITS-1:0] mem_q;
  logic                  vld_q;
  logic [BIN_BITS-1:0]   addr_r;
  logic [BIN_BITS-1:0]   addr_sel;
  logic [LEVEL_BITS-1:0] level;

  logic [CHAN_BITS-1:0]  chan_sel_r;
  logic [BAR_BITS-1:0]   height_r;
  logic [COUNT_BITS-1:0] peak_r;

  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  scale_r;
  logic [DIVC_W-1:0]     div_cnt_r;

  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   peak_ext;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;
  logic [COUNT_BITS-1:0] new_rem;

  logic                  out_valid_r;
  out_item_t             out_data_r;

  always_comb begin
    unique case (chan_sel_r)
      CHAN_GREEN: level = in_data.green_level;
      CHAN_RED:   level = in_data.red_level;
      default:    level = in_data.blue_level;
    endcase
    addr_sel = (in_data.op == OP_READ) ? in_data.bin_index : level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_sel_r <= CHAN_BLUE;
      height_r   <= DEFAULT_CANVAS;
    end else if (cfg_we) begin
      unique case (cfg_data.reg_index)
        REG_CHANNEL_SELECT: chan_sel_r <= cfg_data.wr_data[CHAN_BITS-1:0];
        REG_CANVAS_HEIGHT:  height_r   <= cfg_data.wr_data[BAR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Bin memory: read on accept, write back on count update
  always_ff @(posedge clk) begin
    if (cmd.cnt_upd) begin
      mem[addr_r] <= cnt_inc;
    end
    if (cmd.accept) begin
      mem_q  <= mem[addr_sel];
      vld_q  <= vld_r[addr_sel];
      addr_r <= addr_sel;
    end
  end

  assign cnt_cur = vld_q ? mem_q : '0;
  assign cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      peak_r <= '0;
    end else if (cmd.clear) begin
      vld_r  <= '0;
      peak_r <= '0;
    end else if (cmd.cnt_upd) begin
      vld_r[addr_r] <= 1'b1;
      if (cnt_inc > peak_r) begin
        peak_r <= cnt_inc;
      end
    end
  end

  // Restoring divider, one quotient bit per step; quotient shifts into prod_r
  assign peak_ext = {1'b0, peak_r};
  assign trial    = {prod_r[PROD_W-1:BAR_BITS], prod_r[BAR_BITS-1]};
  assign diff     = trial - peak_ext;
  assign ge       = (trial >= peak_ext);
  assign new_rem  = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      cnt_r     <= cnt_cur;
      prod_r    <= PROD_W'(cnt_cur) * PROD_W'(height_r);
      scale_r   <= (PROD_W'(peak_r) > PROD_W'(height_r));
      div_cnt_r <= DIVC_W'(BAR_BITS - 1);
    end else if (cmd.div_step) begin
      prod_r    <= {new_rem, prod_r[BAR_BITS-2:0], ge};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.bin_total  <= TOTAL_BITS'(cnt_r);
      out_data_r.peak_total <= TOTAL_BITS'(peak_r);
      out_data_r.bar_height <= scale_r ? prod_r[BAR_BITS-1:0] : BAR_BITS'(cnt_r);
    end
  end

  assign status.scale    = scale_r;
  assign status.div_last = (div_cnt_r == '0);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/channel_histogram_with_scaled_bars_top.sv
// ----------------------------------------------------------------------------
// Channel histogram with scaled bars
// 256-bin histogram of one selected color channel with peak and bar scaling.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A pixel count reads the bin memory, then
// increments and writes back the bin. A clear needs no clearing pass: the bins
// carry per-entry valid flops that reset and clear drop at once. A bin read
// passes through the memory read, one multiply and, only when the peak exceeds
// the canvas height, a 10-step restoring divider, then waits while the result
// register is still held by out_ch.ready. The result register lets count and
// clear transactions proceed while an earlier read result is still pending.
// cfg_ch is always ready.
module channel_histogram_with_scaled_bars_top
  import chist_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  chist_stream_if.sink          in_ch,
  chist_stream_if.source        out_ch,
  chist_stream_if.sink          cfg_ch
);

  cmd_t      cmd;
  status_t   status;
  in_item_t  in_data;
  cfg_item_t cfg_data;
  out_item_t out_data;
  logic      out_valid;

  assign in_data      = in_ch.data;
  assign cfg_data     = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  chist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_data.op),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  chist_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/chist_checker.sv
// ----------------------------------------------------------------------------
// Histogram port checker
// Port-level assertions bound to the histogram top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chist_checker
  import chist_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [OP_BITS-1:0] in_op,
  input logic               out_valid,
  input logic               out_ready,
  input logic               cfg_ready
);

  `CHIST_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out valid dropped")
  `CHIST_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid, "result after reset")
  `CHIST_ASSERT(a_cnt_busy, clk, rst_n, in_valid && in_ready && in_op == OP_COUNT |=> !in_ready, "count not busy")
  `CHIST_ASSERT(a_rd_busy, clk, rst_n, in_valid && in_ready && in_op == OP_READ |=> !in_ready, "read not busy")
  `CHIST_ASSERT(a_cfg_rdy, clk, rst_n, cfg_ready, "config not ready")

endmodule

bind channel_histogram_with_scaled_bars_top chist_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.data.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_ready (cfg_ch.ready)
);
